@@ sv/pfa_pkg.sv @@
package pfa_pkg;

  localparam int NUM_BLOCKS      = 8;
  localparam int SLOTS_PER_BLOCK = 8;

  localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SLOT_W = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_BLOCK + 1);

  localparam int OP_W     = 2;
  localparam int BIDX_W   = 3;
  localparam int ADDR_W   = 16;
  localparam int TAG_W    = 32;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int POL_W    = 2;
  localparam int BIU_W    = 4;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 4;

  localparam int S_FIELDS_W = BIDX_W + 2 * ADDR_W + TAG_W + SIZE_W;
  localparam int S_DATA_W   = (S_FIELDS_W + 7) / 8 * 8;
  localparam int M_FIELDS_W = BIDX_W + SIZE_W;
  localparam int M_DATA_W   = (M_FIELDS_W + 7) / 8 * 8;

  localparam logic [OP_W-1:0] OP_DEFINE = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DEFINED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] bidx;
    logic [SIZE_W-1:0] cap;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic              hit;
    logic [BLK_W-1:0]  pick;
    logic [SIZE_W-1:0] best;
  } tok_t;

  typedef struct packed {
    logic              vld;
    logic [BLK_W-1:0]  pick;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } cmt_t;

endpackage

@@ sv/pfa_cell.sv @@
module pfa_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pfa_pkg::BLK_W-1:0] cell_idx_i,
  input  logic [pfa_pkg::POL_W-1:0] fit_policy_i,
  input  logic [pfa_pkg::BIU_W-1:0] blocks_in_use_i,
  input  pfa_pkg::tok_t             tok_i,
  input  pfa_pkg::cmt_t             cmt_i,
  output pfa_pkg::tok_t             tok_o
);
  import pfa_pkg::*;

  logic [SIZE_W-1:0] fs_q, fs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TAG_W-1:0]  tag_q  [SLOTS_PER_BLOCK];
  logic [SIZE_W-1:0] size_q [SLOTS_PER_BLOCK];
  logic [TAG_W-1:0]  tag_up [SLOTS_PER_BLOCK];
  logic [SIZE_W-1:0] size_up[SLOTS_PER_BLOCK];
  tok_t              tok_q, tok_d;

  logic                       active;
  logic                       fits;
  logic [SIZE_W-1:0]          left;
  logic [SLOTS_PER_BLOCK-1:0] first;
  logic [SLOTS_PER_BLOCK-1:0] ge;
  logic                       any_match;
  logic                       run;
  logic [SIZE_W-1:0]          sel_size;
  logic [SIZE_W:0]            sum;
  logic [SIZE_W-1:0]          sat;
  logic                       wr_en;
  logic                       shift_en;

  for (genvar k = 0; k < SLOTS_PER_BLOCK; k++) begin : g_up
    if (k < SLOTS_PER_BLOCK - 1) begin : g_next
      assign tag_up[k]  = tag_q[k+1];
      assign size_up[k] = size_q[k+1];
    end else begin : g_top
      assign tag_up[k]  = tag_q[k];
      assign size_up[k] = size_q[k];
    end
  end

  assign active = 32'(cell_idx_i) < 32'(blocks_in_use_i);
  assign fits   = active && (int'(cnt_q) < SLOTS_PER_BLOCK) && (tok_i.size <= fs_q);
  assign left   = fs_q - tok_i.size;

  always_comb begin
    any_match = 1'b0;
    first     = '0;
    sel_size  = '0;
    run       = 1'b0;
    ge        = '0;
    for (int k = 0; k < SLOTS_PER_BLOCK; k++) begin
      if (!any_match && (k < int'(cnt_q)) && (tag_q[k] == tok_i.tag)) begin
        first[k]  = 1'b1;
        any_match = 1'b1;
        sel_size  = size_q[k];
      end
      run   = run | first[k];
      ge[k] = run;
    end
  end

  assign sum = {1'b0, fs_q} + {1'b0, sel_size};
  assign sat = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];

  always_comb begin
    tok_d    = tok_i;
    fs_d     = fs_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    shift_en = 1'b0;
    if (tok_i.vld) begin
      case (tok_i.op)
        OP_DEFINE: begin
          if (32'(tok_i.bidx) == 32'(cell_idx_i)) begin
            fs_d      = tok_i.cap;
            cnt_d     = '0;
            tok_d.hit = 1'b1;
          end
        end
        OP_ALLOC: begin
          if (fits) begin
            if (!tok_i.hit) begin
              tok_d.hit  = 1'b1;
              tok_d.pick = cell_idx_i;
              tok_d.best = left;
            end else if ((fit_policy_i == POL_BEST && left < tok_i.best) ||
                         (fit_policy_i == POL_WORST && left > tok_i.best)) begin
              tok_d.pick = cell_idx_i;
              tok_d.best = left;
            end
          end
        end
        OP_FREE: begin
          if (active && !tok_i.hit && any_match) begin
            fs_d       = sat;
            cnt_d      = cnt_q - CNT_W'(1);
            shift_en   = 1'b1;
            tok_d.hit  = 1'b1;
            tok_d.pick = cell_idx_i;
            tok_d.best = sat;
          end
        end
        default: ;
      endcase
    end
    if (cmt_i.vld && cmt_i.pick == cell_idx_i) begin
      fs_d  = fs_q - cmt_i.size;
      cnt_d = cnt_q + CNT_W'(1);
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q  <= '0;
      cnt_q <= '0;
      tok_q <= '0;
    end else begin
      fs_q  <= fs_d;
      cnt_q <= cnt_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_q[cnt_q[SLOT_W-1:0]]  <= cmt_i.tag;
      size_q[cnt_q[SLOT_W-1:0]] <= cmt_i.size;
    end else if (shift_en) begin
      for (int k = 0; k < SLOTS_PER_BLOCK; k++) begin
        if (ge[k]) begin
          tag_q[k]  <= tag_up[k];
          size_q[k] <= size_up[k];
        end
      end
    end
  end

  assign tok_o = tok_q;

endmodule

@@ sv/partition_fit_allocator.sv @@
// Fixed-partition allocator with first, best or worst fit over a row of block cells.
// Input stream (s_axis): one request word per handshake; tuser carries the opcode
// (define block, allocate, free by tag), tdata the block index, addresses, tag and size.
// Output stream (m_axis): exactly one result word per request; tuser carries the
// status, tdata the chosen block and its free space after the operation.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 is fit_policy, index 1 is
// blocks_in_use; always ready, write only while no request is in flight.
// A request walks the cell row one block per cycle, each cell searching its own
// slots in parallel; an allocate commits into the picked block when it leaves the row.
// A result passes from the last cell into a result register and then the output register, and
// the input reopens in the cycle that result is first offered, so no new request is taken
// while one walks the row or waits in the result register.
// Reset clears the policy, the block count, all free space and slot counts.
// When m_axis_tready is low the result holds in the output register; one more
// request may be accepted and walked, its result parked until the output frees.
module partition_fit_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // block_index, start_addr, end_addr, tag, req_size, zero pad
  input  logic [pfa_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic [pfa_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // chosen_block, free_after, zero pad
  output logic [pfa_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // status
  output logic [pfa_pkg::STATUS_W-1:0]   m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfa_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pfa_pkg::*;

  logic [POL_W-1:0] fit_policy_q;
  logic [BIU_W-1:0] biu_q;

  logic              accept;
  logic [BIDX_W-1:0] in_bidx;
  logic [ADDR_W-1:0] in_start;
  logic [ADDR_W-1:0] in_end;
  logic [TAG_W-1:0]  in_tag;
  logic [SIZE_W-1:0] in_size;

  tok_t tok [NUM_BLOCKS+1];
  tok_t tok_x;
  cmt_t cmt;

  logic [STATUS_W-1:0] res_status;
  logic [BIDX_W-1:0]   res_blk;
  logic [SIZE_W-1:0]   res_fr;

  logic                busy_q;
  logic                res_vld_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [BIDX_W-1:0]   res_blk_q;
  logic [SIZE_W-1:0]   res_fr_q;
  logic                out_vld_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [BIDX_W-1:0]   out_blk_q;
  logic [SIZE_W-1:0]   out_fr_q;
  logic                move;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= '0;
      biu_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_FIT_POLICY:    fit_policy_q <= cfg_data_i[POL_W-1:0];
        CFG_BLOCKS_IN_USE: biu_q        <= cfg_data_i[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_bidx  = s_axis_tdata[BIDX_W-1:0];
  assign in_start = s_axis_tdata[BIDX_W +: ADDR_W];
  assign in_end   = s_axis_tdata[BIDX_W+ADDR_W +: ADDR_W];
  assign in_tag   = s_axis_tdata[BIDX_W+2*ADDR_W +: TAG_W];
  assign in_size  = s_axis_tdata[BIDX_W+2*ADDR_W+TAG_W +: SIZE_W];

  always_comb begin
    tok[0]      = '0;
    tok[0].vld  = accept;
    tok[0].op   = s_axis_tuser;
    tok[0].bidx = in_bidx;
    tok[0].cap  = (in_end >= in_start) ? in_end - in_start : '0;
    tok[0].tag  = in_tag;
    tok[0].size = in_size;
  end

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    pfa_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cell_idx_i     (BLK_W'(i)),
      .fit_policy_i   (fit_policy_q),
      .blocks_in_use_i(biu_q),
      .tok_i          (tok[i]),
      .cmt_i          (cmt),
      .tok_o          (tok[i+1])
    );
  end

  assign tok_x = tok[NUM_BLOCKS];

  always_comb begin
    cmt.vld  = tok_x.vld && (tok_x.op == OP_ALLOC) && tok_x.hit;
    cmt.pick = tok_x.pick;
    cmt.tag  = tok_x.tag;
    cmt.size = tok_x.size;
  end

  always_comb begin
    res_status = ST_NOTFOUND;
    res_blk    = '0;
    res_fr     = '0;
    case (tok_x.op)
      OP_DEFINE: begin
        res_status = ST_DEFINED;
        res_blk    = tok_x.bidx;
        res_fr     = tok_x.hit ? tok_x.cap : '0;
      end
      OP_ALLOC: begin
        if (tok_x.hit) begin
          res_status = ST_ALLOCATED;
          res_blk    = BIDX_W'(tok_x.pick);
          res_fr     = tok_x.best;
        end else begin
          res_status = ST_NOSPACE;
        end
      end
      OP_FREE: begin
        if (tok_x.hit) begin
          res_status = ST_FREED;
          res_blk    = BIDX_W'(tok_x.pick);
          res_fr     = tok_x.best;
        end
      end
      default: ;
    endcase
  end

  assign move = res_vld_q && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      res_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (tok_x.vld) begin
        res_vld_q <= 1'b1;
      end else if (move) begin
        res_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_x.vld) begin
      res_status_q <= res_status;
      res_blk_q    <= res_blk;
      res_fr_q     <= res_fr;
    end
    if (move) begin
      out_status_q <= res_status_q;
      out_blk_q    <= res_blk_q;
      out_fr_q     <= res_fr_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = M_DATA_W'({out_fr_q, out_blk_q});

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 4;
  localparam int LATENCY        = NUM_BLOCKS + 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int SEGMENTS       = 12;
  localparam int SEG_ITEMS      = 55;
  localparam int SCRIPT_ROWS    = 26;

  localparam logic [OP_W-1:0]  OP_SPARE  = 2'd3;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BIDX_W-1:0] bidx;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   blk;
    logic [SIZE_W-1:0]   free_after;
  } outcome_t;

  typedef enum logic [1:0] {K_ITEM, K_KNOWN, K_POLICY, K_BLOCKS} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    request_t              req;
    logic [CFG_DATA_W-1:0] cfg_val;
    outcome_t              want;
  } row_t;

  localparam request_t NO_REQ = '{OP_DEFINE, 0, 0, 0, 0, 0};
  localparam outcome_t NO_OUT = '{ST_DEFINED, 0, 0};

  row_t script [SCRIPT_ROWS] = '{
    '{K_KNOWN,  '{OP_ALLOC,  0, 0, 0, 0, 0}, 0, '{ST_NOSPACE, 0, 0}},
    '{K_KNOWN,  '{OP_FREE,   0, 0, 0, 0, 0}, 0, '{ST_NOTFOUND, 0, 0}},
    '{K_KNOWN,  '{OP_SPARE, 7, 'hFFFF, 'hFFFF, 'hFFFF_FFFF, 'hFFFF}, 0,
      '{ST_NOTFOUND, 0, 0}},
    '{K_KNOWN,  '{OP_DEFINE, 0, 'h0000, 'hFFFF, 0, 0}, 0, '{ST_DEFINED, 0, 'hFFFF}},
    '{K_KNOWN,  '{OP_DEFINE, 7, 'h1000, 'h0FFF, 0, 0}, 0, '{ST_DEFINED, 7, 0}},
    '{K_KNOWN,  '{OP_DEFINE, 1, 'h0100, 'h0400, 0, 0}, 0, '{ST_DEFINED, 1, 'h0300}},
    '{K_KNOWN,  '{OP_DEFINE, 2, 'h8000, 'h8200, 0, 0}, 0, '{ST_DEFINED, 2, 'h0200}},
    '{K_KNOWN,  '{OP_DEFINE, 3, 'h0000, 'h0800, 0, 0}, 0, '{ST_DEFINED, 3, 'h0800}},
    '{K_BLOCKS, NO_REQ, 2, NO_OUT},
    '{K_KNOWN,  '{OP_ALLOC, 0, 0, 0, 'hFFFF_FFFF, 'hFFFF}, 0, '{ST_ALLOCATED, 0, 0}},
    '{K_KNOWN,  '{OP_ALLOC, 0, 0, 0, 'h5441_4730, 0}, 0, '{ST_ALLOCATED, 0, 0}},
    '{K_KNOWN,  '{OP_ALLOC, 0, 0, 0, 1, 'h0400}, 0, '{ST_NOSPACE, 0, 0}},
    '{K_BLOCKS, NO_REQ, 15, NO_OUT},
    '{K_POLICY, NO_REQ, CFG_DATA_W'(POL_BEST), NO_OUT},
    '{K_ITEM,   '{OP_ALLOC, 0, 0, 0, 1, 'h0100}, 0, NO_OUT},
    '{K_ITEM,   '{OP_ALLOC, 0, 0, 0, 1, 'h0100}, 0, NO_OUT},
    '{K_POLICY, NO_REQ, CFG_DATA_W'(POL_WORST), NO_OUT},
    '{K_ITEM,   '{OP_ALLOC, 0, 0, 0, 2, 'h0100}, 0, NO_OUT},
    '{K_POLICY, NO_REQ, CFG_DATA_W'(POL_SPARE), NO_OUT},
    '{K_ITEM,   '{OP_ALLOC, 0, 0, 0, 3, 'h0010}, 0, NO_OUT},
    '{K_ITEM,   '{OP_FREE,  0, 0, 0, 1, 0}, 0, NO_OUT},
    '{K_KNOWN,  '{OP_FREE,  0, 0, 0, 'hFFFF_FFFF, 0}, 0, '{ST_FREED, 0, 'hFFFF}},
    '{K_ITEM,   '{OP_FREE,  0, 0, 0, 'h5441_4730, 0}, 0, NO_OUT},
    '{K_ITEM,   '{OP_FREE,  0, 0, 0, 'hFFFF_FFFF, 0}, 0, NO_OUT},
    '{K_POLICY, NO_REQ, CFG_DATA_W'(POL_FIRST), NO_OUT},
    '{K_ITEM,   '{OP_ALLOC, 0, 0, 0, 4, 0}, 0, NO_OUT}
  };

  int seg_blocks [SEGMENTS] = '{8, 15, 3, 8, 1, 8, 12, 0, 8, 5, 9, 8};
  logic [POL_W-1:0] seg_policy [4] = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE};
  int src_pct_of_mode [4]  = '{0, 53, 0, 21};
  int sink_pct_of_mode [4] = '{0, 0, 53, 21};

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  logic [POL_W-1:0]  policy_q;
  logic [BIU_W-1:0]  blocks_on;
  logic [SIZE_W-1:0] blk_free [NUM_BLOCKS];
  logic [CNT_W-1:0]  blk_used [NUM_BLOCKS];
  logic [TAG_W-1:0]  held_tag [NUM_BLOCKS][SLOTS_PER_BLOCK];
  logic [SIZE_W-1:0] held_size [NUM_BLOCKS][SLOTS_PER_BLOCK];

  outcome_t pending_outcomes [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int rx_hold        = 0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int n_requests     = 0;
  int n_writes       = 0;
  int n_defined      = 0;
  int n_allocated    = 0;
  int n_nospace      = 0;
  int n_freed        = 0;
  int n_notfound     = 0;

  partition_fit_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void clear_state();
    int i;
    policy_q  = POL_FIRST;
    blocks_on = '0;
    for (i = 0; i < NUM_BLOCKS; i++) begin
      blk_free[i] = '0;
      blk_used[i] = '0;
    end
  endfunction

  function automatic outcome_t compute_outcome(input request_t r);
    outcome_t          o;
    int                n, i, j, k, pick, cnt;
    logic              found;
    logic [SIZE_W-1:0] left, best;
    logic [SIZE_W:0]   sum;
    o     = '{ST_NOTFOUND, '0, '0};
    n     = (blocks_on > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_on);
    found = 1'b0;
    pick  = 0;
    best  = '0;
    case (r.op)
      OP_DEFINE: begin
        o = '{ST_DEFINED, r.bidx, '0};
        if (r.bidx < NUM_BLOCKS) begin
          blk_free[r.bidx] = (r.end_addr >= r.start_addr) ? r.end_addr - r.start_addr : '0;
          blk_used[r.bidx] = '0;
          o.free_after     = blk_free[r.bidx];
        end
      end
      OP_ALLOC: begin
        o = '{ST_NOSPACE, '0, '0};
        for (i = 0; i < n; i++) begin
          if (blk_used[i] < SLOTS_PER_BLOCK && r.size <= blk_free[i]) begin
            left = blk_free[i] - r.size;
            if (!found) begin
              found = 1'b1;
              pick  = i;
              best  = left;
              if (policy_q != POL_BEST && policy_q != POL_WORST) break;
            end else if ((policy_q == POL_BEST && left < best) ||
                         (policy_q == POL_WORST && left > best)) begin
              pick = i;
              best = left;
            end
          end
        end
        if (found) begin
          held_tag[pick][blk_used[pick]]  = r.tag;
          held_size[pick][blk_used[pick]] = r.size;
          blk_used[pick] = blk_used[pick] + CNT_W'(1);
          blk_free[pick] = best;
          o = '{ST_ALLOCATED, BIDX_W'(pick), best};
        end
      end
      OP_FREE: begin
        for (i = 0; i < n; i++) begin
          cnt = (blk_used[i] > SLOTS_PER_BLOCK) ? SLOTS_PER_BLOCK : int'(blk_used[i]);
          for (j = 0; j < cnt; j++) begin
            if (held_tag[i][j] == r.tag) begin
              sum = {1'b0, blk_free[i]} + {1'b0, held_size[i][j]};
              blk_free[i] = sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
              for (k = j; k + 1 < cnt; k++) begin
                held_tag[i][k]  = held_tag[i][k+1];
                held_size[i][k] = held_size[i][k+1];
              end
              blk_used[i] = CNT_W'(cnt - 1);
              o = '{ST_FREED, BIDX_W'(i), blk_free[i]};
              return o;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick, i, b;
    r.bidx       = BIDX_W'($urandom);
    r.start_addr = ADDR_W'($urandom);
    r.end_addr   = ($urandom_range(7) == 0) ? ADDR_W'($urandom)
                                            : r.start_addr + ADDR_W'($urandom_range(0, 'h600));
    r.tag        = ($urandom_range(3) == 0) ? TAG_W'($urandom_range(0, 7)) : TAG_W'($urandom);
    case ($urandom_range(9))
      0:       r.size = '0;
      1:       r.size = SIZE_W'($urandom);
      default: r.size = SIZE_W'($urandom_range(1, 'h100));
    endcase
    pick = $urandom_range(99);
    if (pick < 6) begin
      r.op = OP_DEFINE;
    end else if (pick < 55) begin
      r.op = OP_ALLOC;
    end else if (pick < 94) begin
      r.op = OP_FREE;
      if ($urandom_range(4) != 0) begin
        for (i = 0; i < NUM_BLOCKS; i++) begin
          b = $urandom_range(NUM_BLOCKS - 1);
          if (blk_used[b] != 0) begin
            r.tag = held_tag[b][$urandom_range(int'(blk_used[b]) - 1)];
            break;
          end
        end
      end
    end else begin
      r.op = OP_SPARE;
    end
    return r;
  endfunction

  function automatic void tally(input outcome_t o);
    case (o.status)
      ST_DEFINED:   n_defined++;
      ST_ALLOCATED: n_allocated++;
      ST_NOSPACE:   n_nospace++;
      ST_FREED:     n_freed++;
      default:      n_notfound++;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic drop_source();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drop_source();
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FIT_POLICY) policy_q = val[POL_W-1:0];
    else blocks_on = val;
    n_writes++;
  endtask

  task automatic send_request(input request_t r, input logic known, input outcome_t typed);
    outcome_t got;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_DATA_W - S_FIELDS_W){1'b0}},
                      r.size, r.tag, r.end_addr, r.start_addr, r.bidx};
    s_axis_tuser  <= r.op;
    do @(posedge clk_i); while (!s_axis_tready);
    got = compute_outcome(r);
    pending_outcomes.push_back(known ? typed : got);
    tally(got);
    n_requests++;
  endtask

  always @(posedge clk_i) begin : sink
    outcome_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("word with nothing pending, status", m_axis_tuser, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser != want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tdata[BIDX_W-1:0] != want.blk)
          report_mismatch("chosen_block", m_axis_tdata[BIDX_W-1:0], want.blk);
        if (m_axis_tdata[BIDX_W +: SIZE_W] != want.free_after)
          report_mismatch("free_after", m_axis_tdata[BIDX_W +: SIZE_W], want.free_after);
      end
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    request_t              req;
    logic [CFG_DATA_W-1:0] pol_word;
    int                    idx, seg, k, b;
    clear_state();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (idx = 0; idx < SCRIPT_ROWS; idx++) begin
      case (script[idx].kind)
        K_POLICY: write_reg(CFG_FIT_POLICY, script[idx].cfg_val);
        K_BLOCKS: write_reg(CFG_BLOCKS_IN_USE, script[idx].cfg_val);
        default:  send_request(script[idx].req, script[idx].kind == K_KNOWN,
                               script[idx].want);
      endcase
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      src_idle_pct   = src_pct_of_mode[seg / 3];
      sink_stall_pct = sink_pct_of_mode[seg / 3];
      pol_word = CFG_DATA_W'($urandom_range(15));
      pol_word[POL_W-1:0] = seg_policy[seg % 4];
      write_reg(CFG_FIT_POLICY, pol_word);
      write_reg(CFG_BLOCKS_IN_USE, CFG_DATA_W'(seg_blocks[seg]));
      for (b = 0; b < NUM_BLOCKS; b++) begin
        req      = random_request();
        req.op   = OP_DEFINE;
        req.bidx = BIDX_W'(b);
        send_request(req, 1'b0, NO_OUT);
      end
      for (k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 2 && k == 20) rx_hold = LONG_HOLD;
        if (seg == 5 && k == 30) begin
          drop_source();
          wait_drained();
        end
        send_request(random_request(), 1'b0, NO_OUT);
      end
    end

    drop_source();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    wait_drained();
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("run: %0d requests, %0d register writes, four idle mixes", n_requests, n_writes);
    $display("outcomes: %0d defined, %0d allocated, %0d no space, %0d freed, %0d not found",
             n_defined, n_allocated, n_nospace, n_freed, n_notfound);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
